>>> rtl/fspa_pkg.sv
// Shared types and constants of the fixed-slot pool allocator.
// Holds the request/response beats, the controller-to-datapath command and status structs.
// No dependencies.
`default_nettype none

package fspa_pkg;

    localparam int MAX_SLOTS  = 256;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int CFG_W      = 9;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LINK_W-1:0] NIL_LINK       = LINK_W'(MAX_SLOTS);
    localparam logic [LINK_W-1:0] MAX_CAP        = LINK_W'(MAX_SLOTS);
    localparam logic [CFG_W-1:0]  INIT_SLOTS_RST = CFG_W'(16);

    // Register word index (byte address / 4)
    localparam logic [APB_ADDR_W-3:0] REG_INITIAL_SLOTS = '0;

    // Request kinds
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_RESET  = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic [1:0]        status;
        logic [LINK_W-1:0] used_count;
    } t_rsp;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_GROW,
        DP_ADD_FRESH,
        DP_ADD_READ,
        DP_ADD_LINK,
        DP_FAIL_FULL,
        DP_FAIL_MISS,
        DP_WALK_START,
        DP_WALK_STEP,
        DP_UNLINK,
        DP_RELEASE,
        DP_REBUILD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   ld_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       free_empty;
        logic       at_max;
        logic       rm_ok;
        logic       head_fresh;
        logic       hit;
        logic       rd_nil;
        logic       out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/fspa_ram.sv
// Generic single-port RAM with registered read.
// Used for the link memory; no dependencies.
`default_nettype none

module fspa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/fspa_dp.sv
// Datapath of the pool allocator: list heads, counters, link memory and result register.
// Depends on fspa_pkg and fspa_ram.
`default_nettype none

module fspa_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fspa_pkg::t_req    i_req,
    input  logic [fspa_pkg::CFG_W-1:0] i_init_slots,
    input  fspa_pkg::t_dp_cmd i_cmd,
    output fspa_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fspa_pkg::t_rsp    o_out
);
    import fspa_pkg::*;

    logic [1:0]        r_kind,       n_kind;
    logic [SLOT_W-1:0] r_slot,       n_slot;
    logic [LINK_W-1:0] r_free_head,  n_free_head;
    logic [LINK_W-1:0] r_used_head,  n_used_head;
    logic [LINK_W-1:0] r_in_use,     n_in_use;
    logic [LINK_W-1:0] r_active,     n_active;
    logic [LINK_W-1:0] r_bump,       n_bump;
    logic [LINK_W-1:0] r_node,       n_node;
    logic [LINK_W-1:0] r_prev,       n_prev;
    logic [SLOT_W-1:0] r_res_slot,   n_res_slot;
    logic [1:0]        r_res_status, n_res_status;
    t_rsp              r_out;
    logic              r_out_valid;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_addr;
    logic [LINK_W-1:0] ram_wdata;
    logic [LINK_W-1:0] ram_rdata;

    logic [LINK_W:0]   grow_wide;
    logic [LINK_W-1:0] grown;
    logic [LINK_W-1:0] init_clamped;
    logic [LINK_W-1:0] bump_inc;

    fspa_ram #(
        .WIDTH(LINK_W),
        .DEPTH(MAX_SLOTS)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        grow_wide = {r_active, 1'b0};
        grown     = (grow_wide > (LINK_W+1)'(MAX_SLOTS)) ? MAX_CAP : grow_wide[LINK_W-1:0];
        if (i_init_slots == '0) begin
            init_clamped = LINK_W'(1);
        end else if (i_init_slots > CFG_W'(MAX_SLOTS)) begin
            init_clamped = MAX_CAP;
        end else begin
            init_clamped = LINK_W'(i_init_slots);
        end
        bump_inc = r_bump + LINK_W'(1);
    end

    always_comb begin
        n_kind       = r_kind;
        n_slot       = r_slot;
        n_free_head  = r_free_head;
        n_used_head  = r_used_head;
        n_in_use     = r_in_use;
        n_active     = r_active;
        n_bump       = r_bump;
        n_node       = r_node;
        n_prev       = r_prev;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        ram_we       = 1'b0;
        ram_addr     = r_node[SLOT_W-1:0];
        ram_wdata    = r_used_head;

        unique case (i_cmd.op)
            DP_NOP: begin
            end
            DP_LOAD: begin
                n_kind       = i_req.kind;
                n_slot       = i_req.slot;
                n_res_slot   = i_req.slot;
                n_res_status = ST_OK;
            end
            DP_GROW: begin
                n_active    = grown;
                n_free_head = r_bump;
            end
            DP_ADD_FRESH: begin
                // Head is the next never-used slot: its link is implicit
                n_free_head = (bump_inc < r_active) ? bump_inc : NIL_LINK;
                n_bump      = bump_inc;
                ram_we      = 1'b1;
                ram_addr    = r_free_head[SLOT_W-1:0];
                ram_wdata   = r_used_head;
                n_used_head = r_free_head;
                n_in_use    = r_in_use + LINK_W'(1);
                n_res_slot  = r_free_head[SLOT_W-1:0];
            end
            DP_ADD_READ: begin
                ram_addr = r_free_head[SLOT_W-1:0];
            end
            DP_ADD_LINK: begin
                n_free_head = ram_rdata;
                ram_we      = 1'b1;
                ram_addr    = r_free_head[SLOT_W-1:0];
                ram_wdata   = r_used_head;
                n_used_head = r_free_head;
                n_in_use    = r_in_use + LINK_W'(1);
                n_res_slot  = r_free_head[SLOT_W-1:0];
            end
            DP_FAIL_FULL: begin
                n_res_slot   = '0;
                n_res_status = ST_FULL;
            end
            DP_FAIL_MISS: begin
                n_res_status = ST_MISS;
            end
            DP_WALK_START: begin
                ram_addr = r_used_head[SLOT_W-1:0];
                n_node   = r_used_head;
                n_prev   = NIL_LINK;
            end
            DP_WALK_STEP: begin
                ram_addr = ram_rdata[SLOT_W-1:0];
                n_node   = ram_rdata;
                n_prev   = r_node;
            end
            DP_UNLINK: begin
                if (r_prev == NIL_LINK) begin
                    n_used_head = ram_rdata;
                end else begin
                    ram_we    = 1'b1;
                    ram_addr  = r_prev[SLOT_W-1:0];
                    ram_wdata = ram_rdata;
                end
            end
            DP_RELEASE: begin
                ram_we      = 1'b1;
                ram_addr    = r_node[SLOT_W-1:0];
                ram_wdata   = r_free_head;
                n_free_head = r_node;
                n_in_use    = r_in_use - LINK_W'(1);
            end
            DP_REBUILD: begin
                n_active    = init_clamped;
                n_bump      = '0;
                n_free_head = '0;
                n_used_head = NIL_LINK;
                n_in_use    = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_used_head <= NIL_LINK;
            r_in_use    <= '0;
            r_active    <= LINK_W'(INIT_SLOTS_RST);
            r_bump      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_free_head <= n_free_head;
            r_used_head <= n_used_head;
            r_in_use    <= n_in_use;
            r_active    <= n_active;
            r_bump      <= n_bump;
            if (i_cmd.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_slot       <= n_slot;
        r_node       <= n_node;
        r_prev       <= n_prev;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        if (i_cmd.ld_out) begin
            r_out.slot_out   <= r_res_slot;
            r_out.status     <= r_res_status;
            r_out.used_count <= r_in_use;
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.free_empty = (r_free_head == NIL_LINK);
    assign o_stat.at_max     = (r_active == MAX_CAP);
    assign o_stat.rm_ok      = (r_in_use != '0) && (LINK_W'(r_slot) < r_active);
    assign o_stat.head_fresh = (r_free_head == r_bump);
    assign o_stat.hit        = (r_node == LINK_W'(r_slot));
    assign o_stat.rd_nil     = (ram_rdata == NIL_LINK);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_used_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_use <= r_active)
        else $error("used count exceeds capacity");

    a_bump_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bump <= r_active)
        else $error("fresh-slot counter beyond capacity");

    a_free_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head == NIL_LINK) || (r_free_head < r_active))
        else $error("free head points outside the pool");

endmodule

`default_nettype wire

>>> rtl/fspa_ctrl.sv
// Controller state machine of the pool allocator: sequences add, remove and rebuild.
// Depends on fspa_pkg; drives fspa_dp through command and status structs.
`default_nettype none

module fspa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fspa_pkg::t_dp_stat i_stat,
    output fspa_pkg::t_dp_cmd  o_cmd
);
    import fspa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_POP,
        S_ADD_WAIT,
        S_WALK,
        S_REL,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    logic    r_in_ready;
    t_dp_cmd cmd;

    always_comb begin
        n_state    = r_state;
        cmd.op     = DP_NOP;
        cmd.ld_out = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    cmd.op  = DP_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.kind)
                    KIND_ADD: begin
                        if (i_stat.free_empty && i_stat.at_max) begin
                            cmd.op  = DP_FAIL_FULL;
                            n_state = S_DONE;
                        end else begin
                            if (i_stat.free_empty) begin
                                cmd.op = DP_GROW;
                            end
                            n_state = S_ADD_POP;
                        end
                    end
                    KIND_REMOVE: begin
                        if (i_stat.rm_ok) begin
                            cmd.op  = DP_WALK_START;
                            n_state = S_WALK;
                        end else begin
                            cmd.op  = DP_FAIL_MISS;
                            n_state = S_DONE;
                        end
                    end
                    KIND_RESET: begin
                        cmd.op  = DP_REBUILD;
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ADD_POP: begin
                if (i_stat.head_fresh) begin
                    cmd.op  = DP_ADD_FRESH;
                    n_state = S_DONE;
                end else begin
                    cmd.op  = DP_ADD_READ;
                    n_state = S_ADD_WAIT;
                end
            end
            S_ADD_WAIT: begin
                cmd.op  = DP_ADD_LINK;
                n_state = S_DONE;
            end
            S_WALK: begin
                if (i_stat.hit) begin
                    cmd.op  = DP_UNLINK;
                    n_state = S_REL;
                end else if (i_stat.rd_nil) begin
                    cmd.op  = DP_FAIL_MISS;
                    n_state = S_DONE;
                end else begin
                    cmd.op = DP_WALK_STEP;
                end
            end
            S_REL: begin
                cmd.op  = DP_RELEASE;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd.ld_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = cmd;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready == (r_state == S_IDLE))
        else $error("ready out of step with controller state");

    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && r_in_ready) |=> (!r_in_ready && r_state == S_DISPATCH))
        else $error("accepted beat did not start dispatch");

endmodule

`default_nettype wire

>>> rtl/fixed_slot_pool_allocator_unit.sv
// Top level of the fixed-slot pool allocator: APB register, controller and datapath.
// Depends on fspa_pkg, fspa_ctrl, fspa_dp (and through it fspa_ram).
`default_nettype none

// Fixed-slot pool allocator. Each request beat (add, remove, reset pool) yields
// exactly one response beat carrying the allocated or echoed slot (zero for a
// full pool), a status (ok, pool full, slot not in use) and the used count
// after the request. Slots live on a free list and a used list whose links sit
// in one 256x9 single-port link memory. Never-used slots are handed out in
// ascending order by a fresh-slot counter, so capacity growth and pool reset
// only set counters and list heads and the link memory needs no clearing pass
// after reset: the block takes requests as soon as reset is released. An add
// of a never-used slot pops the free head directly, while a recycled one first
// reads its link from the link memory. Reset pool, unknown kinds, pool-full
// adds and removes rejected on range or an empty pool go straight to the
// response. A remove walks the used list from its head, reading one link per
// cycle through the single link-memory port, and on a match unlinks and
// releases the slot; a walk that reaches the list end reports a miss. The
// response register lets the next request be accepted while a response still
// waits to be taken.
// The initial_slots register (byte address 0, 9 bits, reset 16) sets the
// capacity applied on a reset-pool request; 0 acts as 1 and values above 256
// as 256. Write it only while the block is idle.
module fixed_slot_pool_allocator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  fspa_pkg::t_req                      i_in_data,
    // response channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output fspa_pkg::t_rsp                      o_out_data,
    // APB register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fspa_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fspa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fspa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import fspa_pkg::*;

    logic [CFG_W-1:0] r_init_slots;
    logic             reg_hit;
    logic             reg_wr;
    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;

    // Register decode: word index only, byte lanes ignored
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_INITIAL_SLOTS);
    assign reg_wr  = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;

    // Hold the configured capacity; latch on the access phase of a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_slots <= INIT_SLOTS_RST;
        end else if (reg_wr) begin
            r_init_slots <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = reg_hit ? APB_DATA_W'(r_init_slots) : '0;

    // Sequence each request beat
    fspa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    // Lists, counters, link memory and response register
    fspa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_init_slots(r_init_slots),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

`default_nettype wire
